// File: sv/pft_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pft_pkg
// Shared constants for the packet framer with transmit byte queue.
// ----------------------------------------------------------------------------
package pft_pkg;

  // Queue depth default, handed to the top level
  localparam int QUEUE_DEPTH_DEF = 64;

  // Field widths of the channels
  localparam int TYPE_W    = 3;
  localparam int LEN_W     = 3;
  localparam int PAYLOAD_W = 56;
  localparam int TS_W      = 16;
  localparam int BYTE_W    = 8;
  localparam int FILL_W    = 7;
  localparam int BURST_W   = 4;

  // Command codes
  localparam logic CMD_SEND  = 1'b0;
  localparam logic CMD_DRAIN = 1'b1;

  // Framing constants
  localparam logic [BYTE_W-1:0]  SYNC_BYTE      = 8'hAA;
  localparam logic [BYTE_W-1:0]  HDR_TYPE_MASK  = 8'hE0;
  localparam logic [BYTE_W-1:0]  HDR_LEN_MASK   = 8'h07;
  localparam logic [BURST_W-1:0] MAX_BURST      = 4'd8;
  localparam logic [BURST_W-1:0] BURST_RESET    = 4'd8;
  localparam int                 FRAME_OVERHEAD = 4;

  // Position of each header byte within a frame
  localparam logic [3:0] POS_SYNC  = 4'd0;
  localparam logic [3:0] POS_HDR   = 4'd1;
  localparam logic [3:0] POS_TS_HI = 4'd2;
  localparam logic [3:0] POS_TS_LO = 4'd3;

endpackage

// File: sv/pft_channels.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pft channels
// Valid/ready channel interfaces: command input, result output, config write.
// ----------------------------------------------------------------------------

// Command channel: send packet or drain tick
interface pft_in_if;
  logic                             valid;
  logic                             ready;
  logic                             cmd;
  logic [pft_pkg::TYPE_W-1:0]       type_bits;
  logic [pft_pkg::LEN_W-1:0]        payload_len;
  logic [pft_pkg::PAYLOAD_W-1:0]    payload_bytes;
  logic [pft_pkg::TS_W-1:0]         timestamp;
  logic                             link_powered;
  logic                             link_has_space;

  modport source (output valid, cmd, type_bits, payload_len, payload_bytes, timestamp,
                  link_powered, link_has_space, input ready);
  modport sink   (input valid, cmd, type_bits, payload_len, payload_bytes, timestamp,
                  link_powered, link_has_space, output ready);
endinterface

// Result channel: one word per link byte or per command status
interface pft_out_if;
  logic                          valid;
  logic                          ready;
  logic [pft_pkg::BYTE_W-1:0]    out_byte;
  logic                          out_strobe;
  logic                          packet_accepted;
  logic [pft_pkg::FILL_W-1:0]    fill_level;
  logic                          last;

  modport source (output valid, out_byte, out_strobe, packet_accepted, fill_level, last,
                  input ready);
  modport sink   (input valid, out_byte, out_strobe, packet_accepted, fill_level, last,
                  output ready);
endinterface

// Config write channel: drain burst register
interface pft_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [pft_pkg::BURST_W-1:0]   drain_burst;

  modport source (output valid, drain_burst, input ready);
  modport sink   (input valid, drain_burst, output ready);
endinterface

// File: sv/pft_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pft_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module pft_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    // read data holds while no read is issued
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: sv/packet_framer_tx_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// packet_framer_tx_fifo
// Frames sensor packets into a byte queue in RAM and drains it to the link.
// ----------------------------------------------------------------------------
//  channel  dir  words                       payload
//  req      in   one command                 cmd, type, len, payload, stamp, link flags
//  rsp      out  1 per command, n per drain  byte, strobe, accepted, fill level, last
//  cfg      in   one register write          drain_burst
//
//  One command at a time. A send is accepted, then writes its framed bytes
//  (len+4) in turn into the queue RAM, then posts the status word.
//  A dropped send is accepted, then posts the status word.
//  A drain of n bytes handles each byte as a RAM read (registered data)
//  followed by a load of the output register. An empty drain is accepted, then posts the status word.
//  A stalled rsp holds the current byte; the next word waits for the slot.
//  Reset (rst, synchronous) empties the queue and sets drain_burst to 8.
// ----------------------------------------------------------------------------
module packet_framer_tx_fifo #(
  parameter int  QUEUE_DEPTH = pft_pkg::QUEUE_DEPTH_DEF,
  localparam int IDX_W       = $clog2(QUEUE_DEPTH),
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1)
) (
  input  logic      clk,
  input  logic      rst,
  pft_in_if.sink    req,
  pft_out_if.source rsp,
  pft_cfg_if.sink   cfg
);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_SEND  = 5'b00010,
    S_DRD   = 5'b00100,
    S_DWAIT = 5'b01000,
    S_RESP  = 5'b10000
  } state_t;

  state_t state;

  // queue pointers and config
  logic [IDX_W-1:0]            head;
  logic [IDX_W-1:0]            tail;
  logic [CNT_W-1:0]            count;
  logic [pft_pkg::BURST_W-1:0] drain_burst;

  // latched command
  logic [pft_pkg::TYPE_W-1:0]    type_q;
  logic [pft_pkg::LEN_W-1:0]     len_q;
  logic [pft_pkg::PAYLOAD_W-1:0] payload_q;
  logic [pft_pkg::TS_W-1:0]      ts_q;
  logic [3:0]                    pos;
  logic [pft_pkg::BURST_W-1:0]   remain;
  logic                          acc_q;

  // output register
  logic                         ov;
  logic [pft_pkg::BYTE_W-1:0]   ob;
  logic                         ostb;
  logic                         oacc;
  logic [pft_pkg::FILL_W-1:0]   ofill;
  logic                         olast;

  // RAM ports
  logic                         ram_we;
  logic [pft_pkg::BYTE_W-1:0]   ram_wdata;
  logic                         ram_re;
  logic [pft_pkg::BYTE_W-1:0]   ram_rdata;

  logic                         in_acc;
  logic                         slot_free;
  logic                         ov_load;
  logic                         fits;
  logic [CNT_W:0]               need;
  logic [pft_pkg::BURST_W-1:0]  burst_eff;
  logic [pft_pkg::BURST_W-1:0]  n_drain;
  logic                         link_ok;
  logic [2:0]                   pay_idx;
  logic [3:0]                   last_pos;
  logic [IDX_W-1:0]             head_next;
  logic [IDX_W-1:0]             tail_next;
  logic [CNT_W-1:0]             count_dec;

  assign in_acc    = req.valid && req.ready;
  assign req.ready = (state == S_IDLE);
  assign cfg.ready = 1'b1;
  assign slot_free = !ov || rsp.ready;
  assign ov_load   = ((state == S_DWAIT) || (state == S_RESP)) && slot_free;

  // space check: count + len + overhead <= depth
  assign need = {1'b0, count} + (CNT_W+1)'(req.payload_len)
              + (CNT_W+1)'(pft_pkg::FRAME_OVERHEAD);
  assign fits = (need <= (CNT_W+1)'(QUEUE_DEPTH));

  // drain size: min(burst clipped to 8, queued) when the link is ready
  assign burst_eff = (drain_burst > pft_pkg::MAX_BURST) ? pft_pkg::MAX_BURST : drain_burst;
  assign link_ok   = req.link_powered && req.link_has_space;
  always_comb begin
    n_drain = '0;
    if (link_ok) begin
      if ((CNT_W+1)'(burst_eff) < {1'b0, count}) begin
        n_drain = burst_eff;
      end else begin
        n_drain = pft_pkg::BURST_W'(count);
      end
    end
  end

  // ring pointer wrap
  assign head_next = (head == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : head + 1'b1;
  assign tail_next = (tail == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : tail + 1'b1;
  assign count_dec = count - 1'b1;

  // framed byte select
  assign pay_idx  = 3'(pos - 4'(pft_pkg::FRAME_OVERHEAD));
  assign last_pos = {1'b0, len_q} + 4'(pft_pkg::FRAME_OVERHEAD - 1);
  always_comb begin
    case (pos)
      pft_pkg::POS_SYNC:  ram_wdata = pft_pkg::SYNC_BYTE;
      pft_pkg::POS_HDR:   ram_wdata = ({type_q, 5'b0} & pft_pkg::HDR_TYPE_MASK)
                                    | ({5'b0, len_q} & pft_pkg::HDR_LEN_MASK);
      pft_pkg::POS_TS_HI: ram_wdata = ts_q[15:8];
      pft_pkg::POS_TS_LO: ram_wdata = ts_q[7:0];
      default:            ram_wdata = payload_q[{pay_idx, 3'b000} +: 8];
    endcase
  end

  assign ram_we = (state == S_SEND);
  assign ram_re = (state == S_DRD);

  pft_ram #(
    .WIDTH (pft_pkg::BYTE_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .we    (ram_we),
    .waddr (tail),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (head),
    .rdata (ram_rdata)
  );

  // config register
  always_ff @(posedge clk) begin
    if (rst) begin
      drain_burst <= pft_pkg::BURST_RESET;
    end else if (cfg.valid && cfg.ready) begin
      drain_burst <= cfg.drain_burst;
    end
  end

  // command latch
  always_ff @(posedge clk) begin
    if (in_acc) begin
      type_q    <= req.type_bits;
      len_q     <= req.payload_len;
      payload_q <= req.payload_bytes;
      ts_q      <= req.timestamp;
    end
  end

  // output valid: set on a load, cleared when the word is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      ov <= 1'b0;
    end else if (ov_load) begin
      ov <= 1'b1;
    end else if (rsp.ready) begin
      ov <= 1'b0;
    end
  end

  // sequencer and queue control
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      head   <= '0;
      tail   <= '0;
      count  <= '0;
      pos    <= '0;
      remain <= '0;
      acc_q  <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_acc) begin
            pos <= '0;
            if (req.cmd == pft_pkg::CMD_SEND) begin
              acc_q <= fits;
              state <= fits ? S_SEND : S_RESP;
            end else begin
              acc_q  <= 1'b0;
              remain <= n_drain;
              state  <= (n_drain == '0) ? S_RESP : S_DRD;
            end
          end
        end
        S_SEND: begin
          tail  <= tail_next;
          count <= count + 1'b1;
          pos   <= pos + 1'b1;
          if (pos == last_pos) begin
            state <= S_RESP;
          end
        end
        S_DRD: begin
          state <= S_DWAIT;
        end
        S_DWAIT: begin
          if (slot_free) begin
            head   <= head_next;
            count  <= count_dec;
            remain <= remain - 1'b1;
            state  <= (remain == 4'd1) ? S_IDLE : S_DRD;
          end
        end
        S_RESP: begin
          if (slot_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // output word payload
  always_ff @(posedge clk) begin
    if (state == S_DWAIT && slot_free) begin
      ob    <= ram_rdata;
      ostb  <= 1'b1;
      oacc  <= 1'b0;
      ofill <= pft_pkg::FILL_W'(count_dec);
      olast <= (remain == 4'd1);
    end else if (state == S_RESP && slot_free) begin
      ob    <= '0;
      ostb  <= 1'b0;
      oacc  <= acc_q;
      ofill <= pft_pkg::FILL_W'(count);
      olast <= 1'b1;
    end
  end

  assign rsp.valid           = ov;
  assign rsp.out_byte        = ob;
  assign rsp.out_strobe      = ostb;
  assign rsp.packet_accepted = oacc;
  assign rsp.fill_level      = ofill;
  assign rsp.last            = olast;

endmodule
